>>> sv/tilt_to_cursor_displacement_defines.svh
// Assertion helpers shared by the RTL.
`ifndef TILT_TO_CURSOR_DISPLACEMENT_DEFINES_SVH
`define TILT_TO_CURSOR_DISPLACEMENT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define TTCD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds after ante, delayed by n.
`define TTCD_ASSERT_DELAY(lbl, ante, n, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

>>> sv/ttcd_pkg.sv
`default_nettype none
package ttcd_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int SQ_BITS         = 2 * SAMPLE_BITS;
    localparam int CORDIC_STEPS    = 16;
    localparam int CORDIC_PRESCALE = 20;
    localparam int CW              = SAMPLE_BITS + 24;
    localparam int ZW              = 25;
    localparam int ANGLE_W         = 16;
    localparam int STEP_W          = 7;
    localparam int OUT_W           = 8;
    localparam int CFG_IDX_W       = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_H_STEP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_V_STEP = 1'b1;

    localparam logic [STEP_W-1:0] STEP_RESET = 7'd8;

    localparam logic signed [ZW-1:0]      RIGHT_ANGLE_Q16 = 25'sd5898240;
    localparam logic signed [ZW-1:0]      ROUND_Q16       = 25'sd128;
    localparam logic signed [ANGLE_W-1:0] RIGHT_ANGLE_Q88 = 16'sd23040;

    typedef enum logic [1:0] {
        SPC_NONE,
        SPC_POS,
        SPC_NEG,
        SPC_ZERO
    } special_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] accel_x;
        logic signed [SAMPLE_BITS-1:0] accel_y;
        logic signed [SAMPLE_BITS-1:0] accel_z;
    } sample_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] step_x;
        logic signed [OUT_W-1:0] step_y;
    } result_t;

    // atan(2^-i) in degrees, Q16.16, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_entry(input int idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            0:       v = 25'sd2949120;
            1:       v = 25'sd1740967;
            2:       v = 25'sd919879;
            3:       v = 25'sd466945;
            4:       v = 25'sd234379;
            5:       v = 25'sd117304;
            6:       v = 25'sd58666;
            7:       v = 25'sd29335;
            8:       v = 25'sd14668;
            9:       v = 25'sd7334;
            10:      v = 25'sd3667;
            11:      v = 25'sd1833;
            12:      v = 25'sd917;
            13:      v = 25'sd458;
            14:      v = 25'sd229;
            15:      v = 25'sd115;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> sv/tilt_to_cursor_displacement.sv
`default_nettype none
// Channel        | Ports                         | Handshake
// ---------------+-------------------------------+------------------------------
// sample in      | start, busy, sample           | taken when start && !busy
// result out     | done, result                  | one-cycle strobe, no stall
// register write | cfg_we, cfg_idx, cfg_data     | written when cfg_we is high
//
// Fully pipelined: a new sample is taken every cycle, busy is never raised.
// The pipeline runs through squares, sum, one square-root cell per result
// bit, operand setup, one CORDIC cell per rotation, angle rounding, and
// three scaling stages.
// Reset clears the valid line and loads both step registers with 8.
// The receiver cannot stall; each result shows for exactly one cycle.
`include "tilt_to_cursor_displacement_defines.svh"
module tilt_to_cursor_displacement #(
    parameter int ANGLE_RANGE_DEG = 45
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire ttcd_pkg::sample_t               sample,
    output logic                                 done,
    output ttcd_pkg::result_t                    result,
    input  wire logic                            cfg_we,
    input  wire logic [ttcd_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [ttcd_pkg::STEP_W-1:0]     cfg_data
);
    import ttcd_pkg::*;

    localparam int VLEN = SAMPLE_BITS + CORDIC_STEPS + 7;
    localparam int SB   = SAMPLE_BITS;

    logic accept;
    logic [VLEN-1:0] valid_reg;

    logic [STEP_W-1:0] h_step_reg;
    logic [STEP_W-1:0] v_step_reg;

    // Front: squares, then their sum
    logic signed [SB-1:0]      g0_s1_reg;
    logic signed [SB-1:0]      g1_s1_reg;
    logic signed [SQ_BITS-1:0] sq0_reg;
    logic signed [SQ_BITS-1:0] sq2_reg;
    logic        [SQ_BITS-1:0] n_reg;

    // Square root chain and the matching operand line
    logic        [SQ_BITS-1:0] sq_n    [0:SB];
    logic        [SQ_BITS-1:0] sq_root [0:SB];
    logic signed [SB-1:0]      g0_line_reg [0:SB];
    logic signed [SB-1:0]      g1_line_reg [0:SB];

    // Operand setup
    logic signed [SB:0]   g0_ext;
    logic signed [SB:0]   g1_ext;
    logic signed [SB:0]   roll_x0;
    logic signed [SB:0]   roll_y0;
    logic signed [SB:0]   pitch_x0;
    special_t             roll_spc_next;
    special_t             pitch_spc_next;

    // CORDIC chains
    logic signed [CW-1:0] rx [0:CORDIC_STEPS];
    logic signed [CW-1:0] ry [0:CORDIC_STEPS];
    logic signed [ZW-1:0] rz [0:CORDIC_STEPS];
    logic signed [CW-1:0] px [0:CORDIC_STEPS];
    logic signed [CW-1:0] py [0:CORDIC_STEPS];
    logic signed [ZW-1:0] pz [0:CORDIC_STEPS];
    logic signed [CW-1:0] rx0_reg;
    logic signed [CW-1:0] ry0_reg;
    logic signed [CW-1:0] px0_reg;
    logic signed [CW-1:0] py0_reg;
    special_t             roll_spc_reg  [0:CORDIC_STEPS];
    special_t             pitch_spc_reg [0:CORDIC_STEPS];

    // Angle rounding
    logic signed [ANGLE_W-1:0] roll_next;
    logic signed [ANGLE_W-1:0] pitch_next;
    logic signed [ANGLE_W-1:0] roll_reg;
    logic signed [ANGLE_W-1:0] pitch_reg;

    logic signed [OUT_W-1:0] step_x;
    logic signed [OUT_W-1:0] step_y;

    function automatic logic signed [ANGLE_W-1:0] round_angle(
        input logic signed [ZW-1:0] z,
        input special_t             spc
    );
        logic signed [ZW-1:0] zc;
        logic signed [ZW-1:0] zr;
        logic signed [ANGLE_W-1:0] a;
        if (z > RIGHT_ANGLE_Q16)
            zc = RIGHT_ANGLE_Q16;
        else if (z < -RIGHT_ANGLE_Q16)
            zc = -RIGHT_ANGLE_Q16;
        else
            zc = z;
        zr = (zc + ROUND_Q16) >>> 8;
        unique case (spc)
            SPC_POS:  a = RIGHT_ANGLE_Q88;
            SPC_NEG:  a = -RIGHT_ANGLE_Q88;
            SPC_ZERO: a = '0;
            default:  a = ANGLE_W'(zr);
        endcase
        return a;
    endfunction

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Advance the valid line one stage per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[VLEN-2:0], accept};
    end

    // Hold the step registers; ignore writes while nothing addresses them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_step_reg <= STEP_RESET;
            v_step_reg <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_MAX_H_STEP: h_step_reg <= cfg_data;
                CFG_MAX_V_STEP: v_step_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Body frame: g0 = y, g1 = z, g2 = x
    always_ff @(posedge clk)
    begin
        g0_s1_reg <= sample.accel_y;
        g1_s1_reg <= sample.accel_z;
        sq0_reg   <= sample.accel_y * sample.accel_y;
        sq2_reg   <= sample.accel_x * sample.accel_x;
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= SQ_BITS'(sq0_reg) + SQ_BITS'(sq2_reg);
        g0_line_reg[0] <= g0_s1_reg;
        g1_line_reg[0] <= g1_s1_reg;
    end

    assign sq_n[0]    = n_reg;
    assign sq_root[0] = '0;

    for (genvar k = 0; k < SB; k++)
    begin : g_sqrt
        ttcd_sqrt_cell #(
            .STAGE (k)
        ) u_cell (
            .clk      (clk),
            .n_in     (sq_n[k]),
            .root_in  (sq_root[k]),
            .n_out    (sq_n[k+1]),
            .root_out (sq_root[k+1])
        );

        always_ff @(posedge clk)
        begin
            g0_line_reg[k+1] <= g0_line_reg[k];
            g1_line_reg[k+1] <= g1_line_reg[k];
        end
    end

    // Roll operands keep x >= 0; a zero x drops to a fixed angle
    always_comb
    begin
        g0_ext   = {g0_line_reg[SB][SB-1], g0_line_reg[SB]};
        g1_ext   = {g1_line_reg[SB][SB-1], g1_line_reg[SB]};
        roll_x0  = g1_ext[SB] ? -g1_ext : g1_ext;
        roll_y0  = g1_ext[SB] ? g0_ext : -g0_ext;
        pitch_x0 = $signed({1'b0, sq_root[SB][SB-1:0]});

        if (g1_ext != '0)
            roll_spc_next = SPC_NONE;
        else if (roll_y0 > 0)
            roll_spc_next = SPC_POS;
        else if (roll_y0 < 0)
            roll_spc_next = SPC_NEG;
        else
            roll_spc_next = SPC_ZERO;

        if (pitch_x0 != '0)
            pitch_spc_next = SPC_NONE;
        else if (g1_ext > 0)
            pitch_spc_next = SPC_POS;
        else if (g1_ext < 0)
            pitch_spc_next = SPC_NEG;
        else
            pitch_spc_next = SPC_ZERO;
    end

    always_ff @(posedge clk)
    begin
        rx0_reg          <= CW'(roll_x0) <<< CORDIC_PRESCALE;
        ry0_reg          <= CW'(roll_y0) <<< CORDIC_PRESCALE;
        px0_reg          <= CW'(pitch_x0) <<< CORDIC_PRESCALE;
        py0_reg          <= CW'(g1_ext) <<< CORDIC_PRESCALE;
        roll_spc_reg[0]  <= roll_spc_next;
        pitch_spc_reg[0] <= pitch_spc_next;
    end

    assign rx[0] = rx0_reg;
    assign ry[0] = ry0_reg;
    assign rz[0] = '0;
    assign px[0] = px0_reg;
    assign py[0] = py0_reg;
    assign pz[0] = '0;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        ttcd_cordic_cell #(
            .STAGE (i)
        ) u_roll (
            .clk   (clk),
            .x_in  (rx[i]),
            .y_in  (ry[i]),
            .z_in  (rz[i]),
            .x_out (rx[i+1]),
            .y_out (ry[i+1]),
            .z_out (rz[i+1])
        );

        ttcd_cordic_cell #(
            .STAGE (i)
        ) u_pitch (
            .clk   (clk),
            .x_in  (px[i]),
            .y_in  (py[i]),
            .z_in  (pz[i]),
            .x_out (px[i+1]),
            .y_out (py[i+1]),
            .z_out (pz[i+1])
        );

        always_ff @(posedge clk)
        begin
            roll_spc_reg[i+1]  <= roll_spc_reg[i];
            pitch_spc_reg[i+1] <= pitch_spc_reg[i];
        end
    end

    // Clamp to +/-90 degrees and round Q16.16 down to Q8.8
    always_comb
    begin
        roll_next  = round_angle(rz[CORDIC_STEPS], roll_spc_reg[CORDIC_STEPS]);
        pitch_next = round_angle(pz[CORDIC_STEPS], pitch_spc_reg[CORDIC_STEPS]);
    end

    always_ff @(posedge clk)
    begin
        roll_reg  <= roll_next;
        pitch_reg <= pitch_next;
    end

    ttcd_scale #(
        .ANGLE_RANGE_DEG (ANGLE_RANGE_DEG)
    ) u_scale_x (
        .clk   (clk),
        .step  (h_step_reg),
        .angle (roll_reg),
        .disp  (step_x)
    );

    ttcd_scale #(
        .ANGLE_RANGE_DEG (ANGLE_RANGE_DEG)
    ) u_scale_y (
        .clk   (clk),
        .step  (v_step_reg),
        .angle (pitch_reg),
        .disp  (step_y)
    );

    assign done          = valid_reg[VLEN-1];
    assign result.step_x = step_x;
    assign result.step_y = step_y;

    // Every accepted sample comes out as a done strobe at the end of the valid line
    `TTCD_ASSERT_DELAY(a_latency, accept, VLEN, done, "result strobe missing after latency")
    // A zero step gives no displacement, whatever the tilt
    `TTCD_ASSERT_SAME(a_zero_h, done && h_step_reg == '0, result.step_x == '0, "step_x nonzero")
    `TTCD_ASSERT_SAME(a_zero_v, done && v_step_reg == '0, result.step_y == '0, "step_y nonzero")
endmodule
`default_nettype wire

>>> sv/ttcd_sqrt_cell.sv
`default_nettype none
// One result bit of the digit-by-digit integer square root.
module ttcd_sqrt_cell #(
    parameter int STAGE = 0
) (
    input  wire logic                        clk,
    input  wire logic [ttcd_pkg::SQ_BITS-1:0] n_in,
    input  wire logic [ttcd_pkg::SQ_BITS-1:0] root_in,
    output logic      [ttcd_pkg::SQ_BITS-1:0] n_out,
    output logic      [ttcd_pkg::SQ_BITS-1:0] root_out
);
    import ttcd_pkg::*;

    localparam logic [SQ_BITS-1:0] BIT = SQ_BITS'(1) << (SQ_BITS - 2 - 2 * STAGE);

    logic [SQ_BITS-1:0] trial;
    logic [SQ_BITS-1:0] n_next;
    logic [SQ_BITS-1:0] root_next;
    logic [SQ_BITS-1:0] n_reg;
    logic [SQ_BITS-1:0] root_reg;

    always_comb
    begin
        trial = root_in + BIT;
        if (n_in >= trial)
        begin
            n_next    = n_in - trial;
            root_next = (root_in >> 1) + BIT;
        end
        else
        begin
            n_next    = n_in;
            root_next = root_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        root_reg <= root_next;
    end

    assign n_out    = n_reg;
    assign root_out = root_reg;
endmodule
`default_nettype wire

>>> sv/ttcd_cordic_cell.sv
`default_nettype none
// One vectoring rotation: drive y toward zero, accumulate the angle.
module ttcd_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire logic                          clk,
    input  wire logic signed [ttcd_pkg::CW-1:0] x_in,
    input  wire logic signed [ttcd_pkg::CW-1:0] y_in,
    input  wire logic signed [ttcd_pkg::ZW-1:0] z_in,
    output logic      signed [ttcd_pkg::CW-1:0] x_out,
    output logic      signed [ttcd_pkg::CW-1:0] y_out,
    output logic      signed [ttcd_pkg::ZW-1:0] z_out
);
    import ttcd_pkg::*;

    localparam logic signed [ZW-1:0] ANGLE = atan_entry(STAGE);

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] x_next;
    logic signed [CW-1:0] y_next;
    logic signed [ZW-1:0] z_next;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [ZW-1:0] z_reg;

    always_comb
    begin
        dx = y_in >>> STAGE;
        dy = x_in >>> STAGE;
        if (!y_in[CW-1])
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ANGLE;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ANGLE;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule
`default_nettype wire

>>> sv/ttcd_scale.sv
`default_nettype none
// Scale an angle by step / (range * 256), truncate toward zero, saturate.
module ttcd_scale #(
    parameter int ANGLE_RANGE_DEG = 45
) (
    input  wire logic                               clk,
    input  wire logic        [ttcd_pkg::STEP_W-1:0]  step,
    input  wire logic signed [ttcd_pkg::ANGLE_W-1:0] angle,
    output logic      signed [ttcd_pkg::OUT_W-1:0]   disp
);
    import ttcd_pkg::*;

    localparam int PW    = STEP_W + 1 + ANGLE_W;
    localparam int QW    = 14;
    localparam int SHIFT = QW + 8;
    localparam int RW    = SHIFT + 1;
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << SHIFT) + ANGLE_RANGE_DEG - 1) / ANGLE_RANGE_DEG);
    localparam logic [QW-1:0] POS_LIMIT = QW'(127);
    localparam logic [QW-1:0] NEG_LIMIT = QW'(128);

    logic signed [PW-1:0]    prod_reg;
    logic        [PW-1:0]    mag;
    logic                    neg_reg;
    logic        [QW+RW-1:0] qm_reg;
    logic        [QW-1:0]    quo;
    logic signed [OUT_W-1:0] disp_next;
    logic signed [OUT_W-1:0] disp_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= $signed({1'b0, step}) * angle;
    end

    always_comb
    begin
        mag = prod_reg[PW-1] ? PW'(-prod_reg) : PW'(prod_reg);
    end

    // Truncation: floor(|p| / (256 * range)) = floor(floor(|p| / 256) / range)
    always_ff @(posedge clk)
    begin
        neg_reg <= prod_reg[PW-1];
        qm_reg  <= mag[QW+7:8] * RECIP;
    end

    always_comb
    begin
        quo = QW'(qm_reg >> SHIFT);
        if (!neg_reg)
            disp_next = (quo > POS_LIMIT) ? OUT_W'(127) : OUT_W'(quo);
        else
            disp_next = (quo > NEG_LIMIT) ? -OUT_W'(128) : OUT_W'(-quo);
    end

    always_ff @(posedge clk)
    begin
        disp_reg <= disp_next;
    end

    assign disp = disp_reg;
endmodule
`default_nettype wire
